/* hw/rtl/cket_pkg.sv */
package cket_pkg;

  // Build defaults
  localparam int DEPTH_DEFAULT = 64;

  // Fixed field widths
  localparam int ACTION_W    = 3;
  localparam int KEY_W       = 16;
  localparam int LEVEL_W     = 8;
  localparam int SLOT_W      = 6;
  localparam int COUNT_OUT_W = 7;
  localparam int CAP_W       = 7;

  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  // Request codes
  typedef enum logic [ACTION_W-1:0] {
    ACT_ADD    = 3'd0,
    ACT_REMOVE = 3'd1,
    ACT_FIND   = 3'd2,
    ACT_READ   = 3'd3,
    ACT_CLEAR  = 3'd4
  } action_t;

  // Sequencer states
  typedef enum logic {
    ST_IDLE,
    ST_APPLY
  } state_t;

  // Broadcast control from the sequencer to every cell
  typedef struct packed {
    logic               capture;   // latch the per-cell compare
    logic               by_index;  // compare position instead of key
    logic [KEY_W-1:0]   cmp_key;
    logic [SLOT_W-1:0]  cmp_slot;
    logic               write_en;  // append at the current count
    logic               shift_en;  // close the gap at the picked position
    logic [KEY_W-1:0]   wr_key;
    logic [LEVEL_W-1:0] wr_level;
  } cell_ctrl_t;

endpackage

/* hw/rtl/cket_cell.sv */
module cket_cell #(
  parameter int INDEX   = 0,
  parameter int COUNT_W = 7,
  parameter int POS_W   = 6
) (
  input  logic                         clk,
  input  logic                         rst,
  input  cket_pkg::cell_ctrl_t         ctrl,
  input  logic [COUNT_W-1:0]           count,
  input  logic [POS_W-1:0]             pos,
  input  logic [cket_pkg::KEY_W-1:0]   nb_key,
  input  logic [cket_pkg::LEVEL_W-1:0] nb_level,
  output logic [cket_pkg::KEY_W-1:0]   entry_key,
  output logic [cket_pkg::LEVEL_W-1:0] entry_level,
  output logic                         pick
);

  localparam logic [31:0] MY_POS = 32'(INDEX);

  logic live;
  logic hit;

  // Entry is occupied when its position is below the count
  assign live = MY_POS < 32'(count);
  assign hit  = ctrl.by_index ? (32'(ctrl.cmp_slot) == MY_POS) : (ctrl.cmp_key == entry_key);

  // Compare result, taken when a request is accepted
  always_ff @(posedge clk) begin
    if (rst) begin
      pick <= 1'b0;
    end else if (ctrl.capture) begin
      pick <= live && hit;
    end
  end

  // Entry storage: append here, or take the upper neighbor on a remove
  always_ff @(posedge clk) begin
    if (ctrl.write_en && (MY_POS == 32'(count))) begin
      entry_key   <= ctrl.wr_key;
      entry_level <= ctrl.wr_level;
    end else if (ctrl.shift_en && (MY_POS >= 32'(pos))) begin
      entry_key   <= nb_key;
      entry_level <= nb_level;
    end
  end

endmodule

/* hw/rtl/compact_keyed_entry_table_top.sv */
// Channel   | Handshake            | Payload
// ----------+----------------------+------------------------------------------
// cfg       | cfg_valid/cfg_ready  | cfg_data (capacity in use)
// request   | in_valid/in_ready    | action, key, level, slot
// result    | out_valid/out_ready  | ok, found_slot, found_key, found_level,
//           |                      | entry_count
//
// For each request, at the accept edge every cell latches its own key or
// position compare; then, in the apply state, the one-hot pick row is
// encoded, the cells append or shift, and the result register loads.
// A new request is taken only after the previous result is loaded.
// If the result register is still full, the update cycle waits for out_ready.
// Reset empties the table and sets capacity to 64; entries are not cleared.
module compact_keyed_entry_table_top #(
  parameter int TABLE_DEPTH = cket_pkg::DEPTH_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [cket_pkg::CAP_W-1:0]          cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [cket_pkg::ACTION_W-1:0]       action,
  input  logic [cket_pkg::KEY_W-1:0]          key,
  input  logic [cket_pkg::LEVEL_W-1:0]        level,
  input  logic [cket_pkg::SLOT_W-1:0]         slot,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                ok,
  output logic [cket_pkg::SLOT_W-1:0]         found_slot,
  output logic [cket_pkg::KEY_W-1:0]          found_key,
  output logic [cket_pkg::LEVEL_W-1:0]        found_level,
  output logic [cket_pkg::COUNT_OUT_W-1:0]    entry_count
);

  localparam int COUNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int POS_W   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CMP_W   = (COUNT_W > cket_pkg::CAP_W) ? COUNT_W : cket_pkg::CAP_W;

  cket_pkg::state_t state, state_next;

  logic [cket_pkg::CAP_W-1:0]    capacity;
  logic [COUNT_W-1:0]            count, count_next;
  logic [cket_pkg::ACTION_W-1:0] req_action;
  logic [cket_pkg::KEY_W-1:0]    req_key;
  logic [cket_pkg::LEVEL_W-1:0]  req_level;

  logic                          accept;
  logic                          apply_fire;
  logic                          found;
  logic                          room;
  logic [CMP_W-1:0]              cap_lim;

  logic [cket_pkg::KEY_W-1:0]    cell_key   [TABLE_DEPTH];
  logic [cket_pkg::LEVEL_W-1:0]  cell_level [TABLE_DEPTH];
  logic [cket_pkg::KEY_W-1:0]    nb_key     [TABLE_DEPTH];
  logic [cket_pkg::LEVEL_W-1:0]  nb_level   [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0]        pick;

  logic [cket_pkg::KEY_W-1:0]    pick_key;
  logic [cket_pkg::LEVEL_W-1:0]  pick_level;
  logic [POS_W-1:0]              pick_pos;

  logic                          res_ok;
  logic [POS_W-1:0]              res_pos;
  logic [cket_pkg::KEY_W-1:0]    res_key;
  logic [cket_pkg::LEVEL_W-1:0]  res_level;
  logic                          do_write;
  logic                          do_shift;

  cket_pkg::cell_ctrl_t          ctrl;

  // Configuration register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= cket_pkg::CAP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      capacity <= cfg_data;
    end
  end

  // Sequencer: next state
  always_comb begin
    state_next = state;
    unique case (state)
      cket_pkg::ST_IDLE:  if (accept) state_next = cket_pkg::ST_APPLY;
      cket_pkg::ST_APPLY: if (apply_fire) state_next = cket_pkg::ST_IDLE;
      default:            state_next = cket_pkg::ST_IDLE;
    endcase
  end

  // Sequencer: outputs
  always_comb begin
    in_ready   = 1'b0;
    apply_fire = 1'b0;
    unique case (state)
      cket_pkg::ST_IDLE:  in_ready = 1'b1;
      cket_pkg::ST_APPLY: apply_fire = !out_valid || out_ready;
      default:            in_ready = 1'b0;
    endcase
  end

  assign accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cket_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Request holding registers
  always_ff @(posedge clk) begin
    if (accept) begin
      req_action <= action;
      req_key    <= key;
      req_level  <= level;
    end
  end

  // Row of cells
  assign ctrl.capture  = accept;
  assign ctrl.by_index = (action == cket_pkg::ACT_READ);
  assign ctrl.cmp_key  = key;
  assign ctrl.cmp_slot = slot;
  assign ctrl.write_en = apply_fire && do_write;
  assign ctrl.shift_en = apply_fire && do_shift;
  assign ctrl.wr_key   = req_key;
  assign ctrl.wr_level = req_level;

  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    if (g == TABLE_DEPTH - 1) begin : g_last
      assign nb_key[g]   = cell_key[g];
      assign nb_level[g] = cell_level[g];
    end else begin : g_mid
      assign nb_key[g]   = cell_key[g+1];
      assign nb_level[g] = cell_level[g+1];
    end

    cket_cell #(
      .INDEX   (g),
      .COUNT_W (COUNT_W),
      .POS_W   (POS_W)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctrl        (ctrl),
      .count       (count),
      .pos         (pick_pos),
      .nb_key      (nb_key[g]),
      .nb_level    (nb_level[g]),
      .entry_key   (cell_key[g]),
      .entry_level (cell_level[g]),
      .pick        (pick[g])
    );
  end

  // At most one cell picks: collapse the row with AND-OR
  always_comb begin
    pick_key   = '0;
    pick_level = '0;
    pick_pos   = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      pick_key   = pick_key   | (cell_key[i]   & {cket_pkg::KEY_W{pick[i]}});
      pick_level = pick_level | (cell_level[i] & {cket_pkg::LEVEL_W{pick[i]}});
      pick_pos   = pick_pos   | (POS_W'(i)     & {POS_W{pick[i]}});
    end
  end

  assign found = |pick;

  // Capacity saturated to the built depth
  always_comb begin
    if (CMP_W'(capacity) < CMP_W'(TABLE_DEPTH)) begin
      cap_lim = CMP_W'(capacity);
    end else begin
      cap_lim = CMP_W'(TABLE_DEPTH);
    end
  end

  assign room = CMP_W'(count) < cap_lim;

  // Outcome of the held request
  always_comb begin
    res_ok     = 1'b0;
    res_pos    = '0;
    res_key    = '0;
    res_level  = '0;
    count_next = count;
    do_write   = 1'b0;
    do_shift   = 1'b0;
    unique case (req_action)
      cket_pkg::ACT_ADD: begin
        if (!found && room) begin
          res_ok     = 1'b1;
          res_pos    = POS_W'(count);
          res_key    = req_key;
          res_level  = req_level;
          count_next = count + 1'b1;
          do_write   = 1'b1;
        end
      end
      cket_pkg::ACT_REMOVE: begin
        if (found) begin
          res_ok     = 1'b1;
          res_pos    = pick_pos;
          res_key    = pick_key;
          res_level  = pick_level;
          count_next = count - 1'b1;
          do_shift   = 1'b1;
        end
      end
      cket_pkg::ACT_FIND, cket_pkg::ACT_READ: begin
        if (found) begin
          res_ok    = 1'b1;
          res_pos   = pick_pos;
          res_key   = pick_key;
          res_level = pick_level;
        end
      end
      cket_pkg::ACT_CLEAR: begin
        res_ok     = 1'b1;
        count_next = '0;
      end
      default: begin
        res_ok = 1'b0;
      end
    endcase
  end

  // Entry count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (apply_fire) begin
      count <= count_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (apply_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (apply_fire) begin
      ok          <= res_ok;
      found_slot  <= cket_pkg::SLOT_W'(res_pos);
      found_key   <= res_key;
      found_level <= res_level;
      entry_count <= cket_pkg::COUNT_OUT_W'(count_next);
    end
  end

endmodule

/* hw/rtl/cket_checker.sv */
module cket_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             in_valid,
  input logic                             in_ready,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic                             ok,
  input logic [cket_pkg::SLOT_W-1:0]      found_slot,
  input logic [cket_pkg::KEY_W-1:0]       found_key,
  input logic [cket_pkg::LEVEL_W-1:0]     found_level,
  input logic [cket_pkg::COUNT_OUT_W-1:0] entry_count
);

  // Reset leaves no result pending and the request side open
  a_reset_clean: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("result pending or request side closed after reset");

  // One request at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second request taken while one is in work");

  // With the result side free, the apply state after the request loads the result without waiting
  a_latency: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !out_valid |=> ##1 out_valid)
    else $error("result missing two cycles after request");

  // A failed request reports no entry
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !ok |-> found_slot == '0 && found_key == '0 && found_level == '0)
    else $error("failed result carries entry fields");

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(ok) && $stable(found_slot)
      && $stable(found_key) && $stable(found_level) && $stable(entry_count))
    else $error("stalled result changed");

endmodule

bind compact_keyed_entry_table_top cket_checker u_cket_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .ok          (ok),
  .found_slot  (found_slot),
  .found_key   (found_key),
  .found_level (found_level),
  .entry_count (entry_count)
);
